### hdl/arsm_pkg.sv
package arsm_pkg;

  localparam int MaxRangesDef = 64;
  localparam int AddrBitsDef  = 32;
  localparam int InAddrBits   = 32;
  localparam int FieldBits    = 7;
  localparam int StatusBits   = 2;

  localparam logic [StatusBits-1:0] StatusOk      = 2'd0;
  localparam logic [StatusBits-1:0] StatusFull    = 2'd1;
  localparam logic [StatusBits-1:0] StatusBadSpan = 2'd2;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

endpackage

### hdl/address_range_set_merge_top.sv
// Keeps a sorted table of disjoint, non-adjacent inclusive address ranges held in two
// single-port-write RAMs (starts and ends). A lookup is a binary search; each probe passes
// through a read, a wait and a compare state. An insert scans the table from the bottom, one
// entry per read, to find the touched span, and checks the first touched entry again as
// an end candidate. It then moves entries one at a time (read, wait, write): opening a slot
// or closing a gap after a merge shifts every entry above it. Scan and move together pass
// over the table about once. The RAM read latency and the single compare unit set the pace.
// One item is handled at a time; in_stall is high until the result is taken.
module address_range_set_merge_top #(
  parameter int MAX_RANGES = arsm_pkg::MaxRangesDef,
  parameter int ADDR_BITS  = arsm_pkg::AddrBitsDef
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic [arsm_pkg::InAddrBits-1:0]      first_addr,
  input  logic [arsm_pkg::InAddrBits-1:0]      last_addr,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [arsm_pkg::FieldBits-1:0]       position,
  output logic [arsm_pkg::StatusBits-1:0]      status,
  output logic [arsm_pkg::FieldBits-1:0]       range_count
);
  import arsm_pkg::*;

  localparam int IdxBits = $clog2(MAX_RANGES);
  localparam int CntBits = $clog2(MAX_RANGES + 1);
  localparam logic [ADDR_BITS-1:0] AllOnes = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LREAD  = 4'd1;
  localparam logic [3:0] S_LWAIT  = 4'd2;
  localparam logic [3:0] S_LCMP   = 4'd3;
  localparam logic [3:0] S_IREAD  = 4'd4;
  localparam logic [3:0] S_IWAIT  = 4'd5;
  localparam logic [3:0] S_ICMP   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_MREAD  = 4'd8;
  localparam logic [3:0] S_MWAIT  = 4'd9;
  localparam logic [3:0] S_MWRITE = 4'd10;
  localparam logic [3:0] S_PUT    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]           state;
  logic [CntBits-1:0]   count;
  logic [ADDR_BITS-1:0] sa, ea;
  logic [CntBits-1:0]   lo, hi, ptr;
  logic                 phase;      // insert scan: 0 finds lo, 1 finds hi
  logic                 grow;       // shift up (new slot) vs down (merge)
  logic [CntBits-1:0]   gone;
  logic [ADDR_BITS-1:0] ns, ne;

  logic                 we;
  logic [IdxBits-1:0]   waddr, raddr;
  logic [ADDR_BITS-1:0] wstart, wend, rstart, rend;

  arsm_ram #(.Width(ADDR_BITS), .Depth(MAX_RANGES)) u_starts (
    .clk, .we, .waddr, .wdata(wstart), .raddr, .rdata(rstart));
  arsm_ram #(.Width(ADDR_BITS), .Depth(MAX_RANGES)) u_ends (
    .clk, .we, .waddr, .wdata(wend), .raddr, .rdata(rend));

  logic [CntBits-1:0] mid;
  assign mid = lo + ((hi - lo) >> 1);

  logic end_touch, start_beyond;
  assign end_touch    = (rend >= sa) || (rend != AllOnes && rend + 1'b1 == sa);
  assign start_beyond = (rstart > ea) && !(ea != AllOnes && ea + 1'b1 == rstart);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    raddr = ptr[IdxBits-1:0];
    if (state == S_LREAD) begin
      raddr = mid[IdxBits-1:0];
    end
  end

  // write strobe is registered from the state that prepares the write data, so it is high in the cycle after that state
  always_ff @(posedge clk) begin
    if (rst) begin
      we <= 1'b0;
    end else begin
      we <= (state == S_MWRITE) || (state == S_PUT) || (state == S_DECIDE && lo != hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sa <= ADDR_BITS'(first_addr);
            ea <= ADDR_BITS'(last_addr);
            lo <= '0;
            hi <= count;
            ptr <= '0;
            phase <= 1'b0;
            if (operation == OpLookup) begin
              state <= S_LREAD;
            end else if (ADDR_BITS'(first_addr) > ADDR_BITS'(last_addr)) begin
              found <= 1'b0;
              position <= '0;
              status <= StatusBadSpan;
              state <= S_DONE;
            end else begin
              state <= S_IREAD;
            end
          end
        end
        S_LREAD: begin
          if (lo < hi) begin
            ptr <= mid;
            state <= S_LWAIT;
          end else begin
            found <= 1'b0;
            position <= FieldBits'(lo);
            status <= StatusOk;
            state <= S_DONE;
          end
        end
        S_LWAIT: state <= S_LCMP;
        S_LCMP: begin
          if (sa < rstart) begin
            hi <= ptr;
            state <= S_LREAD;
          end else if (sa > rend) begin
            lo <= ptr + 1'b1;
            state <= S_LREAD;
          end else begin
            found <= 1'b1;
            position <= FieldBits'(ptr);
            status <= StatusOk;
            state <= S_DONE;
          end
        end
        S_IREAD: begin
          if (ptr < count) begin
            state <= S_IWAIT;
          end else begin
            if (!phase) lo <= ptr;
            hi <= ptr;
            state <= S_DECIDE;
          end
        end
        S_IWAIT: state <= S_ICMP;
        S_ICMP: begin
          if (!phase) begin
            if (end_touch) begin
              lo <= ptr;
              ns <= (rstart < sa) ? rstart : sa;
              phase <= 1'b1;
              state <= S_IWAIT;   // same entry, check as hi candidate next
            end else begin
              ptr <= ptr + 1'b1;
              state <= S_IREAD;
            end
          end else begin
            if (start_beyond) begin
              hi <= ptr;
              state <= S_DECIDE;
            end else begin
              ne <= (rend > ea) ? rend : ea;
              ptr <= ptr + 1'b1;
              state <= S_IREAD;
            end
          end
        end
        S_DECIDE: begin
          found <= 1'b0;
          position <= FieldBits'(lo);
          if (lo == hi) begin
            if (count >= CntBits'(MAX_RANGES)) begin
              status <= StatusFull;
              state <= S_DONE;
            end else begin
              status <= StatusOk;
              grow <= 1'b1;
              ptr <= count;
              state <= S_MREAD;
            end
          end else begin
            status <= StatusOk;
            grow <= 1'b0;
            gone <= hi - lo - 1'b1;
            waddr <= lo[IdxBits-1:0];
            wstart <= ns;
            wend <= ne;
            ptr <= hi;
            state <= S_MREAD;
          end
        end
        S_MREAD: begin
          if (grow) begin
            if (ptr > lo) begin
              ptr <= ptr - 1'b1;
              state <= S_MWAIT;
            end else begin
              state <= S_PUT;
            end
          end else if (gone != '0 && ptr < count) begin
            state <= S_MWAIT;
          end else begin
            count <= count - gone;
            state <= S_DONE;
          end
        end
        S_MWAIT: state <= S_MWRITE;
        S_MWRITE: begin
          wstart <= rstart;
          wend <= rend;
          if (grow) begin
            waddr <= IdxBits'(ptr + 1'b1);
          end else begin
            waddr <= IdxBits'(ptr - gone);
            ptr <= ptr + 1'b1;
          end
          state <= S_MREAD;
        end
        S_PUT: begin
          waddr <= lo[IdxBits-1:0];
          wstart <= sa;
          wend <= ea;
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            range_count <= FieldBits'(count);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/arsm_ram.sv
module arsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import arsm_pkg::*;

  localparam int NumRandom  = 650;
  localparam int CycleLimit = 2000000;
  localparam int DrainWait  = 1000;
  localparam logic [31:0] TopAddr = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                  found;
    logic [FieldBits-1:0]  position;
    logic [StatusBits-1:0] status;
    logic [FieldBits-1:0]  range_count;
  } span_result_t;

  typedef struct {
    logic         op;
    logic [31:0]  a;
    logic [31:0]  b;
    bit           typed;
    span_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OpInsert;
  logic [InAddrBits-1:0] first_addr = '0;
  logic [InAddrBits-1:0] last_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [FieldBits-1:0] position;
  logic [StatusBits-1:0] status;
  logic [FieldBits-1:0] range_count;

  // predictor state: sorted disjoint ranges
  logic [31:0] span_lo[MaxRangesDef];
  logic [31:0] span_hi[MaxRangesDef];
  int span_cnt = 0;

  span_result_t pending_results[$];
  stim_row_t dir_rows[$];
  bit failed = 1'b0;
  int cycles = 0;
  bit rx_taken = 1'b0;
  int rx_hold = 0;
  bit rx_quiet = 1'b0;

  address_range_set_merge_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .first_addr(first_addr), .last_addr(last_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .position(position), .status(status), .range_count(range_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit touches_above(logic [31:0] x, logic [31:0] y);
    return x != TopAddr && x + 32'd1 == y;
  endfunction

  function automatic span_result_t apply_span_op(logic op, logic [31:0] a, logic [31:0] b);
    span_result_t r;
    int lo, hi, mid, gone;
    logic [31:0] ns, ne;
    r = '0;
    if (op == OpLookup) begin
      lo = 0;
      hi = span_cnt;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (a < span_lo[mid]) hi = mid;
        else if (a > span_hi[mid]) lo = mid + 1;
        else begin
          r.found = 1'b1;
          break;
        end
      end
      r.position = r.found ? FieldBits'(mid) : FieldBits'(lo);
    end else if (a > b) begin
      r.status = StatusBadSpan;
    end else begin
      lo = 0;
      while (lo < span_cnt && !(span_hi[lo] >= a || touches_above(span_hi[lo], a))) lo++;
      hi = lo;
      while (hi < span_cnt && !(span_lo[hi] > b && !touches_above(b, span_lo[hi]))) hi++;
      r.position = FieldBits'(lo);
      if (lo == hi) begin
        if (span_cnt >= MaxRangesDef) r.status = StatusFull;
        else begin
          for (int i = span_cnt; i > lo; i--) begin
            span_lo[i] = span_lo[i-1];
            span_hi[i] = span_hi[i-1];
          end
          span_lo[lo] = a;
          span_hi[lo] = b;
          span_cnt++;
        end
      end else begin
        ns = span_lo[lo] < a ? span_lo[lo] : a;
        ne = span_hi[hi-1] > b ? span_hi[hi-1] : b;
        gone = hi - lo - 1;
        span_lo[lo] = ns;
        span_hi[lo] = ne;
        for (int i = hi; i < span_cnt; i++) begin
          span_lo[i-gone] = span_lo[i];
          span_hi[i-gone] = span_hi[i];
        end
        span_cnt -= gone;
      end
    end
    r.range_count = FieldBits'(span_cnt);
    return r;
  endfunction

  // called at a falling edge; valid stays up into the next item when there is no gap
  task automatic send_op(logic op, logic [31:0] a, logic [31:0] b, bit typed,
                         span_result_t typed_res, int gap);
    span_result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    first_addr <= a;
    last_addr <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_span_op(op, a, b);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  function automatic void add_row(logic op, logic [31:0] a, logic [31:0] b, bit typed = 0,
                                  logic f = 0, int p = 0, logic [1:0] s = StatusOk, int c = 0);
    stim_row_t row;
    row.op = op;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.res = '{found: f, position: FieldBits'(p), status: s, range_count: FieldBits'(c)};
    dir_rows.push_back(row);
  endfunction

  // result checker
  always @(posedge clk) begin
    span_result_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      rx_taken = 1'b1;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, found);
          failed = 1'b1;
        end
        if (position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, position);
          failed = 1'b1;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          failed = 1'b1;
        end
        if (range_count !== e.range_count) begin
          $error("range_count: expected %0d, got %0d", e.range_count, range_count);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver stall per transfer
  always @(negedge clk) begin
    if (rx_taken) begin
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 16);
      rx_taken = 1'b0;
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic op;
    logic [31:0] a, b, base;
    int kind, gap;
    bit tx_quiet;

    add_row(OpLookup, 32'd0, 32'd0, 1, 0, 0, StatusOk, 0);
    add_row(OpInsert, TopAddr, 32'd0, 1, 0, 0, StatusBadSpan, 0);
    add_row(OpInsert, 32'd5, 32'd4, 1, 0, 0, StatusBadSpan, 0);
    add_row(OpInsert, 32'd0, 32'd0, 1, 0, 0, StatusOk, 1);
    add_row(OpInsert, TopAddr, TopAddr, 1, 0, 1, StatusOk, 2);
    add_row(OpLookup, TopAddr, 32'd0, 1, 1, 1, StatusOk, 2);
    add_row(OpLookup, 32'd0, TopAddr, 1, 1, 0, StatusOk, 2);
    add_row(OpInsert, 32'd10, 32'd20);
    add_row(OpInsert, 32'd21, 32'd30);      // adjacent above
    add_row(OpInsert, 32'd5, 32'd9);        // adjacent below
    add_row(OpLookup, 32'd5, 32'd0);
    add_row(OpLookup, 32'd31, 32'd0);
    add_row(OpLookup, 32'd3, 32'd0);
    add_row(OpInsert, 32'hFFFF_FFFE, 32'hFFFF_FFFE);  // merges into top range
    add_row(OpInsert, 32'd40, 32'd50);
    add_row(OpInsert, 32'd60, 32'd70);
    add_row(OpInsert, 32'd45, 32'd65);      // spans two ranges
    add_row(OpInsert, 32'd2, 32'd2);
    add_row(OpLookup, 32'hFFFF_FFFD, 32'd0);
    add_row(OpLookup, 32'd71, 32'd0);
    add_row(OpInsert, 32'h8000_0000, 32'h8000_0000);
    add_row(OpLookup, 32'h7FFF_FFFF, 32'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
              dir_rows[i].res, $urandom_range(0, 3));

    tx_quiet = 1'b0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 60 == 0) begin
        tx_quiet = $urandom_range(0, 3) == 0;
        rx_quiet = $urandom_range(0, 3) == 0;
      end
      if (n == NumRandom / 2) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      case ($urandom_range(0, 2))
        0: base = 32'd0;
        1: base = 32'h8000_0000;
        default: base = 32'hFFFF_F000;
      endcase
      a = base + $urandom_range(0, 1000) * 4;
      if ($urandom_range(0, 19) == 0) a = TopAddr - $urandom_range(0, 3);
      b = a + $urandom_range(0, 8);
      if (b < a) b = TopAddr;
      kind = $urandom_range(0, 99);
      op = OpInsert;
      if (kind >= 55 && kind < 85) begin
        op = OpLookup;
        a = a + $urandom_range(0, 8);
      end else if (kind >= 85 && kind < 92) begin
        op = OpLookup;
        a = $urandom;
        b = $urandom;
      end else if (kind >= 92 && kind < 94) begin
        a = $urandom;
        b = $urandom;
      end else if (kind >= 94 && b != a) begin
        {a, b} = {b, a};    // broken span
      end
      gap = tx_quiet ? 0 : $urandom_range(0, 16);
      send_op(op, a, b, 1'b0, '0, gap);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/arsm_pkg.sv
hdl/arsm_ram.sv
hdl/address_range_set_merge_top.sv
sim/tb_top.sv
